// File: hdl/line_segment_rect_clip_assert.svh
// Assertion macros shared by the clipping block.
`ifndef LINE_SEGMENT_RECT_CLIP_ASSERT_SVH
`define LINE_SEGMENT_RECT_CLIP_ASSERT_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define LSRC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Antecedent implies consequent after a delay given by dly.
`define LSRC_ASSERT_DLY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
      else $error("assertion failed");
`else
`define LSRC_ASSERT_IMP(label, clk, rst, ante, cons)
`define LSRC_ASSERT_DLY(label, clk, rst, ante, dly, cons)
`endif
`endif

// File: hdl/lsrc_pkg.sv
// Package with widths, types and codes of the segment clipping block.
`timescale 1ns / 1ps
package lsrc_pkg;
   localparam int COORD_BITS = 13;
   localparam int FRAC_BITS = 16;
   localparam int PARAM_BITS = FRAC_BITS + 1;
   localparam int MAG_BITS = COORD_BITS;
   localparam int REM_BITS = MAG_BITS + 1;
   localparam int LANES = 4;
   localparam int STEPS_PER_STAGE = 3;
   localparam int DIV_STAGES = (PARAM_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int PIPE_LATENCY = DIV_STAGES + 3;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [PARAM_BITS-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PARAM_BITS-1:0] SAT_Q = {1'b1, {(FRAC_BITS-1){1'b0}}, 1'b1};

   localparam logic [CSR_IDX_BITS-1:0] CSR_LEFT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOTTOM = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOP = 2'd3;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_ENTER,
      KIND_EXIT
   } lane_kind_type;

   typedef struct packed {
      lane_kind_type kind;
      logic sat;
      logic [REM_BITS-1:0] rem;
      logic [MAG_BITS-1:0] den;
      logic [PARAM_BITS-1:0] quo;
   } lane_type;
endpackage

// File: hdl/line_segment_rect_clip.sv
// Liang-Barsky clipping of one segment against a window, fully pipelined.
// After start, an item passes the setup, divider, combine and output registers in turn.
// Throughput: one item per cycle; busy is always low since the pipeline never stalls.
// The depth is set by the four restoring dividers, up to three quotient bits per stage.
// Synchronous reset clears the valid bits and sets all window edges to zero.
// Results cannot be held off by the receiver: rsp_strobe lasts exactly one cycle.
`timescale 1ns / 1ps
`include "line_segment_rect_clip_assert.svh"
module line_segment_rect_clip
   import lsrc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_strobe,
   output logic                         rsp_outside,
   output logic [PARAM_BITS-1:0]        rsp_enter_param,
   output logic [PARAM_BITS-1:0]        rsp_leave_param,
   input  logic                         csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [COORD_BITS-1:0]        csr_write_data
);

   // Window registers. The user must change them only while no item is in flight; not enforced here.
   logic signed [COORD_BITS-1:0] left_ff, right_ff, bottom_ff, top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         right_ff <= '0;
         bottom_ff <= '0;
         top_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LEFT: left_ff <= csr_write_data;
            CSR_RIGHT: right_ff <= csr_write_data;
            CSR_BOTTOM: bottom_ff <= csr_write_data;
            CSR_TOP: top_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // The pipeline always moves, so a new item is taken in every cycle.
   assign busy = 1'b0;

   // Setup stage: terms p and q for the four sides of the window, then each side is
   // sorted as entry candidate, exit candidate, nothing or outside. The
   // quotient only matters up to 1.0; a numerator above the denominator
   // saturates the quotient just above 1.0, which gives the same compares.
   logic signed [COORD_BITS:0] dx, dy;
   logic signed [COORD_BITS:0] p_term [LANES];
   logic signed [COORD_BITS:0] q_term [LANES];
   lane_type lane_in [DIV_STAGES+1][LANES];
   lane_type lane_ff [DIV_STAGES+1][LANES];
   logic valid_in [DIV_STAGES+1];
   logic valid_ff [DIV_STAGES+1];
   logic flag_in [DIV_STAGES+1];
   logic flag_ff [DIV_STAGES+1];

   always_comb begin
      logic [COORD_BITS:0] pmag, qmag;
      logic [REM_BITS-1:0] rem;
      logic [PARAM_BITS-1:0] quo;
      dx = {req_end_x[COORD_BITS-1], req_end_x} - {req_start_x[COORD_BITS-1], req_start_x};
      dy = {req_end_y[COORD_BITS-1], req_end_y} - {req_start_y[COORD_BITS-1], req_start_y};
      p_term[0] = -dx;
      p_term[1] = dx;
      p_term[2] = -dy;
      p_term[3] = dy;
      q_term[0] = {req_start_x[COORD_BITS-1], req_start_x} - {left_ff[COORD_BITS-1], left_ff};
      q_term[1] = {right_ff[COORD_BITS-1], right_ff} - {req_start_x[COORD_BITS-1], req_start_x};
      q_term[2] = {req_start_y[COORD_BITS-1], req_start_y}
                  - {bottom_ff[COORD_BITS-1], bottom_ff};
      q_term[3] = {top_ff[COORD_BITS-1], top_ff} - {req_start_y[COORD_BITS-1], req_start_y};

      valid_in[0] = start;
      flag_in[0] = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         pmag = p_term[k][COORD_BITS] ? -p_term[k] : p_term[k];
         qmag = q_term[k][COORD_BITS] ? -q_term[k] : q_term[k];
         lane_in[0][k].kind = KIND_NONE;
         lane_in[0][k].den = pmag[MAG_BITS-1:0];
         lane_in[0][k].rem = {1'b0, qmag[MAG_BITS-1:0]};
         lane_in[0][k].quo = '0;
         lane_in[0][k].sat = qmag[MAG_BITS-1:0] > pmag[MAG_BITS-1:0];
         if (p_term[k][COORD_BITS]) begin
            if (q_term[k][COORD_BITS] || (q_term[k] == '0)) begin
               lane_in[0][k].kind = KIND_ENTER;
            end
         end else if (p_term[k] != '0) begin
            if (q_term[k][COORD_BITS]) begin
               flag_in[0] = 1'b1;
            end else begin
               lane_in[0][k].kind = KIND_EXIT;
            end
         end else if (q_term[k][COORD_BITS]) begin
            flag_in[0] = 1'b1;
         end
      end

      // Divider stages: restoring division, up to three quotient bits per stage.
      for (int s = 0; s < DIV_STAGES; s++) begin
         valid_in[s+1] = valid_ff[s];
         flag_in[s+1] = flag_ff[s];
         for (int k = 0; k < LANES; k++) begin
            lane_in[s+1][k] = lane_ff[s][k];
            rem = lane_ff[s][k].rem;
            quo = lane_ff[s][k].quo;
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
               if (s * STEPS_PER_STAGE + j < PARAM_BITS) begin
                  if (rem >= {1'b0, lane_ff[s][k].den}) begin
                     rem = rem - {1'b0, lane_ff[s][k].den};
                     quo = {quo[PARAM_BITS-2:0], 1'b1};
                  end else begin
                     quo = {quo[PARAM_BITS-2:0], 1'b0};
                  end
                  rem = {rem[REM_BITS-2:0], 1'b0};
               end
            end
            lane_in[s+1][k].rem = rem;
            lane_in[s+1][k].quo = quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
         lane_ff[s] <= lane_in[s];
         flag_ff[s] <= flag_in[s];
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   // Combine stage: largest entry quotient and smallest exit quotient.
   logic [PARAM_BITS-1:0] u1_in, u2_in, u1_ff, u2_ff;
   logic [PARAM_BITS-1:0] cand [LANES];
   logic comb_valid_ff, comb_flag_ff;

   always_comb begin
      u1_in = '0;
      u2_in = ONE_Q;
      for (int k = 0; k < LANES; k++) begin
         cand[k] = lane_ff[DIV_STAGES][k].sat ? SAT_Q : lane_ff[DIV_STAGES][k].quo;
         if ((lane_ff[DIV_STAGES][k].kind == KIND_ENTER) && (cand[k] > u1_in)) begin
            u1_in = cand[k];
         end
         if ((lane_ff[DIV_STAGES][k].kind == KIND_EXIT) && (cand[k] < u2_in)) begin
            u2_in = cand[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      u1_ff <= u1_in;
      u2_ff <= u2_in;
      comb_flag_ff <= flag_ff[DIV_STAGES];
      if (reset) begin
         comb_valid_ff <= 1'b0;
      end else begin
         comb_valid_ff <= valid_ff[DIV_STAGES];
      end
   end

   // Output stage: final outside test; an outside segment reads 0 and 1.0.
   logic outside_in;
   logic rsp_strobe_ff, rsp_outside_ff;
   logic [PARAM_BITS-1:0] rsp_enter_ff, rsp_leave_ff;

   assign outside_in = comb_flag_ff || (u1_ff > u2_ff);

   always_ff @(posedge clock) begin
      rsp_outside_ff <= outside_in;
      rsp_enter_ff <= outside_in ? '0 : u1_ff;
      rsp_leave_ff <= outside_in ? ONE_Q : u2_ff;
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= comb_valid_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_outside = rsp_outside_ff;
   assign rsp_enter_param = rsp_enter_ff;
   assign rsp_leave_param = rsp_leave_ff;

   // Every accepted item comes out as a result strobe once it has passed the pipeline registers.
   `LSRC_ASSERT_DLY(a_latency, clock, reset, start, PIPE_LATENCY, rsp_strobe)
   // An outside result carries the normalized parameters.
   `LSRC_ASSERT_IMP(a_outside_norm, clock, reset, rsp_strobe && rsp_outside,
      (rsp_enter_param == '0) && (rsp_leave_param == ONE_Q))
   // An inside result has an ordered parameter pair within one.
   `LSRC_ASSERT_IMP(a_inside_order, clock, reset, rsp_strobe && !rsp_outside,
      (rsp_enter_param <= rsp_leave_param) && (rsp_leave_param <= ONE_Q))
endmodule
